@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL of the range assign / count block.
// Depends on nothing; expects clk and rst_n to exist in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset
`define RAC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked out of reset
`define RAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RAC_ASSERT_SAME(lbl, ante, cons, msg)
`define RAC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ src/rac_pkg.sv @@
// Shared constants for the range assign / count-equal block.
// No dependencies.
package rac_pkg;

  localparam int DATA_W      = 32;
  localparam int COUNT_W     = 11;
  localparam int INDEX_W     = 10;
  localparam int LEN_W       = 11;

  localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

  // Operation codes carried on the command field
  localparam logic CMD_COUNT  = 1'b0;
  localparam logic CMD_ASSIGN = 1'b1;

endpackage

@@ src/range_assign_count_equal_top.sv @@
// Range assign / count-equal over a blocked array; uses rac_pkg and assert_macros.svh.
// From acceptance: a bad range goes straight to the result; otherwise the sequencer scans
// block tags up to the range, visits each touched block, sweeps element by element in a
// partial or unfilled block, and drains the last read of each swept block on a count.
// Throughput: one transaction at a time; in_stall holds until the result is loaded.
// Reset: every block carries a zero fill mark, so no clearing pass; length = 1024.
module range_assign_count_equal_top
  import rac_pkg::*;
#(
  parameter int MAX_LENGTH = 1024,
  parameter int BLOCK_SIZE = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_command,
  input  logic [INDEX_W-1:0]       in_first_index,
  input  logic [INDEX_W-1:0]       in_last_index,
  input  logic signed [DATA_W-1:0] in_operand_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [COUNT_W-1:0]       out_match_count,
  output logic                     out_range_error,
  input  logic                     cfg_wr_en,
  input  logic [LEN_W-1:0]         cfg_wr_data
);

  localparam int NUM_BLOCKS = (MAX_LENGTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int IW = $clog2(MAX_LENGTH);
  localparam int BW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int SW = $clog2(NUM_BLOCKS * BLOCK_SIZE + 2 * BLOCK_SIZE + 1);
  localparam int LW = ($clog2(MAX_LENGTH + 1) > LEN_W) ? $clog2(MAX_LENGTH + 1) : LEN_W;
  localparam logic [SW-1:0] LAST_ELEM = SW'(MAX_LENGTH - 1);
  localparam logic [SW-1:0] FIRST_END =
    (BLOCK_SIZE - 1 < MAX_LENGTH - 1) ? SW'(BLOCK_SIZE - 1) : SW'(MAX_LENGTH - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_FILL  = 3'd2;
  localparam logic [2:0] ST_SWEEP = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  // Control state
  logic [2:0]            state_r, state_nxt;
  logic [LEN_W-1:0]      length_r, length_nxt;
  logic [NUM_BLOCKS-1:0] fill_valid_r, fill_valid_nxt;
  logic [NUM_BLOCKS-1:0] fill_zero_r, fill_zero_nxt;
  logic                  rd_pend_r, rd_pend_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Transaction payload and sequencer datapath
  logic                  cmd_r, cmd_nxt;
  logic [SW-1:0]         first_r, first_nxt;
  logic [SW-1:0]         last_r, last_nxt;
  logic [DATA_W-1:0]     val_r, val_nxt;
  logic                  err_r, err_nxt;
  logic [COUNT_W-1:0]    count_r, count_nxt;
  logic [BW-1:0]         cur_block_r, cur_block_nxt;
  logic [SW-1:0]         cur_start_r, cur_start_nxt;
  logic [SW-1:0]         cur_end_r, cur_end_nxt;
  logic [SW-1:0]         elem_idx_r, elem_idx_nxt;
  logic [SW-1:0]         sweep_end_r, sweep_end_nxt;
  logic                  push_mode_r, push_mode_nxt;
  logic [DATA_W-1:0]     fill_hold_r, fill_hold_nxt;
  logic [COUNT_W-1:0]    out_count_r, out_count_nxt;
  logic                  out_err_r, out_err_nxt;

  // Memories
  logic [DATA_W-1:0]     elem_mem [MAX_LENGTH];
  logic [DATA_W-1:0]     fill_mem [NUM_BLOCKS];
  logic [DATA_W-1:0]     elem_q;
  logic [DATA_W-1:0]     fill_rd_q;
  logic                  elem_we;
  logic [DATA_W-1:0]     elem_wdata;
  logic                  fill_we;

  // Range check and block geometry
  logic [LW-1:0]         len_ext, len_eff, last_ext;
  logic                  in_err;
  logic                  accept;
  logic                  full_block;
  logic [SW-1:0]         lo, hi, span;
  logic [SW-1:0]         nxt_end_raw;
  logic                  blk_fill_valid;
  logic [DATA_W-1:0]     blk_fill_val;

  // Shared comparator
  logic [DATA_W-1:0]     eq_lhs;
  logic                  eq_hit;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  // Validate the range against the effective length
  assign len_ext  = LW'(length_r);
  assign len_eff  = (len_ext > LW'(MAX_LENGTH)) ? LW'(MAX_LENGTH) : len_ext;
  assign last_ext = LW'(in_last_index);
  assign in_err   = (in_first_index > in_last_index) || (last_ext >= len_eff);

  // Clip the range to the current block
  assign full_block  = (first_r <= cur_start_r) && (last_r >= cur_end_r);
  assign lo          = (first_r > cur_start_r) ? first_r : cur_start_r;
  assign hi          = (last_r < cur_end_r) ? last_r : cur_end_r;
  assign span        = hi - lo + SW'(1);
  assign nxt_end_raw = cur_start_r + SW'(2 * BLOCK_SIZE - 1);

  assign blk_fill_valid = fill_valid_r[cur_block_r];
  assign blk_fill_val   = fill_zero_r[cur_block_r] ? '0 : fill_rd_q;

  assign eq_lhs = (state_r == ST_FILL) ? blk_fill_val : elem_q;
  assign eq_hit = (eq_lhs == val_r);

  // Sequencer
  always_comb begin
    logic adv;
    adv            = 1'b0;
    state_nxt      = state_r;
    length_nxt     = cfg_wr_en ? cfg_wr_data : length_r;
    fill_valid_nxt = fill_valid_r;
    fill_zero_nxt  = fill_zero_r;
    rd_pend_nxt    = 1'b0;
    out_valid_nxt  = out_valid_r && out_stall;
    cmd_nxt        = cmd_r;
    first_nxt      = first_r;
    last_nxt       = last_r;
    val_nxt        = val_r;
    err_nxt        = err_r;
    count_nxt      = count_r;
    cur_block_nxt  = cur_block_r;
    cur_start_nxt  = cur_start_r;
    cur_end_nxt    = cur_end_r;
    elem_idx_nxt   = elem_idx_r;
    sweep_end_nxt  = sweep_end_r;
    push_mode_nxt  = push_mode_r;
    fill_hold_nxt  = fill_hold_r;
    out_count_nxt  = out_count_r;
    out_err_nxt    = out_err_r;
    elem_we        = 1'b0;
    elem_wdata     = val_r;
    fill_we        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt       = in_command;
          first_nxt     = SW'(in_first_index);
          last_nxt      = SW'(in_last_index);
          val_nxt       = in_operand_value;
          err_nxt       = in_err;
          count_nxt     = '0;
          cur_block_nxt = '0;
          cur_start_nxt = '0;
          cur_end_nxt   = FIRST_END;
          state_nxt     = in_err ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Walk block tags until the range is reached or passed
        if (cur_start_r > last_r) begin
          state_nxt = ST_DONE;
        end else if (cur_end_r < first_r) begin
          adv = 1'b1;
        end else begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        if (cmd_r == CMD_ASSIGN) begin
          if (full_block) begin
            // Whole block: mark a lazy fill only
            fill_we                     = 1'b1;
            fill_valid_nxt[cur_block_r] = 1'b1;
            fill_zero_nxt[cur_block_r]  = 1'b0;
            adv                         = 1'b1;
            state_nxt                   = ST_SCAN;
          end else if (blk_fill_valid) begin
            // Push the pending fill down and write the range in one pass
            push_mode_nxt               = 1'b1;
            fill_hold_nxt               = blk_fill_val;
            fill_valid_nxt[cur_block_r] = 1'b0;
            elem_idx_nxt                = cur_start_r;
            sweep_end_nxt               = cur_end_r;
            state_nxt                   = ST_SWEEP;
          end else begin
            push_mode_nxt = 1'b0;
            elem_idx_nxt  = lo;
            sweep_end_nxt = hi;
            state_nxt     = ST_SWEEP;
          end
        end else begin
          if (blk_fill_valid) begin
            // Filled block: every covered element equals the fill
            if (eq_hit) begin
              count_nxt = count_r + COUNT_W'(span);
            end
            adv       = 1'b1;
            state_nxt = ST_SCAN;
          end else begin
            push_mode_nxt = 1'b0;
            elem_idx_nxt  = lo;
            sweep_end_nxt = hi;
            state_nxt     = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        if (cmd_r == CMD_ASSIGN) begin
          elem_we = 1'b1;
          if (push_mode_r && ((elem_idx_r < first_r) || (elem_idx_r > last_r))) begin
            elem_wdata = fill_hold_r;
          end
        end else begin
          rd_pend_nxt = 1'b1;
        end
        // Count the element read in the previous cycle
        if (rd_pend_r && eq_hit) begin
          count_nxt = count_r + COUNT_W'(1);
        end
        if (elem_idx_r == sweep_end_r) begin
          if (cmd_r == CMD_ASSIGN) begin
            adv       = 1'b1;
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_DRAIN;
          end
        end else begin
          elem_idx_nxt = elem_idx_r + SW'(1);
        end
      end
      ST_DRAIN: begin
        if (rd_pend_r && eq_hit) begin
          count_nxt = count_r + COUNT_W'(1);
        end
        adv       = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_DONE: begin
        // Hand the result over once the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = count_r;
          out_err_nxt   = err_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Advance to the next block
    if (adv) begin
      cur_block_nxt = cur_block_r + BW'(1);
      cur_start_nxt = cur_start_r + SW'(BLOCK_SIZE);
      cur_end_nxt   = (nxt_end_raw > LAST_ELEM) ? LAST_ELEM : nxt_end_raw;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      length_r     <= LEN_RESET;
      fill_valid_r <= '1;
      fill_zero_r  <= '1;
      rd_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      length_r     <= length_nxt;
      fill_valid_r <= fill_valid_nxt;
      fill_zero_r  <= fill_zero_nxt;
      rd_pend_r    <= rd_pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload and datapath registers
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    first_r     <= first_nxt;
    last_r      <= last_nxt;
    val_r       <= val_nxt;
    err_r       <= err_nxt;
    count_r     <= count_nxt;
    cur_block_r <= cur_block_nxt;
    cur_start_r <= cur_start_nxt;
    cur_end_r   <= cur_end_nxt;
    elem_idx_r  <= elem_idx_nxt;
    sweep_end_r <= sweep_end_nxt;
    push_mode_r <= push_mode_nxt;
    fill_hold_r <= fill_hold_nxt;
    out_count_r <= out_count_nxt;
    out_err_r   <= out_err_nxt;
  end

  // Element store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (elem_we) begin
      elem_mem[elem_idx_r[IW-1:0]] <= elem_wdata;
    end
    elem_q <= elem_mem[elem_idx_r[IW-1:0]];
  end

  // Block fill values: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[cur_block_r] <= val_r;
    end
    fill_rd_q <= fill_mem[cur_block_r];
  end

  assign out_valid       = out_valid_r;
  assign out_match_count = out_count_r;
  assign out_range_error = out_err_r;

`include "assert_macros.svh"

  `RAC_ASSERT_SAME(a_err_zero_count, out_valid && out_range_error,
                   out_match_count == '0, "range error result carries a non-zero count")
  `RAC_ASSERT_NEXT(a_err_to_done, accept && in_err,
                   state_r == ST_DONE, "bad range did not go straight to result")
  `RAC_ASSERT_SAME(a_sweep_in_block, state_r == ST_SWEEP,
                   (elem_idx_r >= cur_start_r) && (elem_idx_r <= cur_end_r),
                   "element sweep left its block")
  `RAC_ASSERT_NEXT(a_count_keeps_fills, (state_r != ST_IDLE) && (cmd_r == CMD_COUNT),
                   $stable(fill_valid_r), "count transaction changed fill marks")

endmodule
